// ----- hw/rtl/avf_pkg.sv -----
// avf_pkg: shared types and constants of the autoranging voltmeter front end
// register indexes, range limits, reset gains, sequencer states, multiplier request
// no dependencies
package avf_pkg;

  localparam int GAIN_REGS = 5;
  localparam int FRAC_BITS = 14;
  localparam int MUL_W     = 32;
  localparam int ALPHA_W   = 17;
  localparam int COOL_W    = 16;
  localparam int MODE_W    = 3;
  localparam int RANGE_W   = 3;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_200MV = 3'd0;
  localparam logic [2:0] REG_GAIN_1000V = 3'd4;
  localparam logic [2:0] REG_ALPHA      = 3'd5;
  localparam logic [2:0] REG_COOLDOWN   = 3'd6;
  localparam logic [2:0] REG_MODE       = 3'd7;

  localparam logic [MODE_W-1:0] MODE_AUTO = 3'd5;

  localparam logic [ALPHA_W-1:0] ALPHA_MIN = 17'd655;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd16384;
  localparam logic [COOL_W-1:0]  COOL_RST  = 16'd200;

  localparam logic [31:0] GAIN_RST [GAIN_REGS] = '{
    32'd125123, 32'd1251225, 32'd12512253, 32'd125122581, 32'd625612903
  };

  // overload limit per range, and the 90% / 20% autorange thresholds
  localparam logic [31:0] LIMIT_UV [GAIN_REGS] = '{
    32'd250000, 32'd2500000, 32'd25000000, 32'd250000000, 32'd1200000000
  };
  localparam logic [31:0] UP_UV [GAIN_REGS] = '{
    32'd225000, 32'd2250000, 32'd22500000, 32'd225000000, 32'd1080000000
  };
  localparam logic [31:0] DN_UV [GAIN_REGS] = '{
    32'd50000, 32'd500000, 32'd5000000, 32'd50000000, 32'd240000000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_SMOOTH,
    ST_MUL,
    ST_EVAL
  } avf_state_t;

  typedef struct packed {
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

endpackage

// ----- hw/rtl/avf_mul.sv -----
// avf_mul: shared 32 x 32 unsigned multiplier with registered product
// depends on avf_pkg
module avf_mul (
  input  logic                           clk,
  input  avf_pkg::mul_req_t              req,
  output logic [2*avf_pkg::MUL_W-1:0]    prod_r
);
  import avf_pkg::*;

  logic [2*MUL_W-1:0] prod_nxt;

  assign prod_nxt = (2*MUL_W)'(req.op_a) * (2*MUL_W)'(req.op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- hw/rtl/autorange_voltmeter_frontend_unit.sv -----
// autorange_voltmeter_frontend_unit: top level of the voltmeter front end
// smoothing filter, gain scaling and autorange sequencer around one multiplier
// depends on avf_pkg and avf_mul
//
// One transfer on the in_ channel carries an ADC code and a millisecond
// timestamp; one transfer on the out_ channel returns the reading for it.
// The code is smoothed by an exponentially weighted average (seeded from the
// first nonzero sample while the average is zero), scaled by the gain of the
// active range to microvolts, and in automatic mode the range steps up one
// above 90% of its overload limit or down one below 20%, at most once per
// cooldown. The filter product and the gain products all go through a single
// registered 32 x 32 multiplier, one product per pass; an item that causes
// a range step takes a second gain product for the new range. in_ready comes
// back high at the same edge at which out_valid rises. in_ready is low while
// an item is in work; a finished result sits in the output register and the
// next item is taken while it waits, but a result only stalls the sequencer if
// the previous one has still not been taken. The cfg_ channel is always ready
// and should be written only while no item is in work.
module autorange_voltmeter_frontend_unit #(
  parameter int ADC_BITS    = 10,
  parameter int RANGE_COUNT = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ADC_BITS-1:0]           in_adc_code,
  input  logic [31:0]                   in_now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_voltage_uv,
  output logic [avf_pkg::RANGE_W-1:0]   out_range_index,
  output logic                          out_range_changed,
  output logic                          out_overloaded,
  output logic                          out_overload_changed,
  output logic [23:0]                   out_filtered_code,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import avf_pkg::*;

  // smoothed value width, reading width and filter accumulator width
  localparam int SW = ADC_BITS + FRAC_BITS;
  localparam int UW = SW + 10;
  localparam int AW = SW + 18;
  localparam int TOP_INT = ((RANGE_COUNT < GAIN_REGS) ? RANGE_COUNT : GAIN_REGS) - 1;
  localparam logic [RANGE_W-1:0] TOP       = RANGE_W'(TOP_INT);
  localparam logic [RANGE_W-1:0] RANGE_RST = (TOP_INT < 2) ? TOP : RANGE_W'(2);

  // configuration registers
  logic [31:0]         gain_r [GAIN_REGS];
  logic [ALPHA_W-1:0]  alpha_r;
  logic [COOL_W-1:0]   cool_r;
  logic [MODE_W-1:0]   mode_r;

  // sequencer and item state
  avf_state_t          state_r, state_nxt;
  logic [ADC_BITS-1:0] code_r;
  logic [31:0]         now_r;
  logic [SW-1:0]       s_r, s_nxt;
  logic [RANGE_W-1:0]  range_r, range_nxt;
  logic [31:0]         last_r, last_nxt;
  logic                prior_ovl_r, prior_ovl_nxt;
  logic                chg_r, chg_nxt;
  logic                neg_r, neg_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         uv_out_r;
  logic [RANGE_W-1:0]  range_out_r;
  logic                chg_out_r, ovl_out_r, ovl_chg_out_r;
  logic [23:0]         filt_out_r;

  // datapath
  mul_req_t            mreq;
  logic [2*MUL_W-1:0]  prod_r;
  logic [ALPHA_W-1:0]  a_eff;
  logic [SW-1:0]       x_val, mag;
  logic [AW-1:0]       acc_base, acc_prod, acc;
  logic [SW+31:0]      prod_rnd;
  logic [UW-1:0]       uv;
  logic                auto_mode, cool_ok, go_up, go_dn, step, over, slot_free, load;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GAIN_REGS; i++) begin
        gain_r[i] <= GAIN_RST[i];
      end
      alpha_r <= ALPHA_RST;
      cool_r  <= COOL_RST;
      mode_r  <= MODE_AUTO;
    end else if (cfg_valid) begin
      if (cfg_index inside {[REG_GAIN_200MV:REG_GAIN_1000V]}) begin
        gain_r[cfg_index] <= cfg_data;
      end else begin
        case (cfg_index)
          REG_ALPHA:    alpha_r <= cfg_data[ALPHA_W-1:0];
          REG_COOLDOWN: cool_r  <= cfg_data[COOL_W-1:0];
          REG_MODE:     mode_r  <= cfg_data[MODE_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  // ------------------------------------------------------- shared multiplier
  // alpha clamped to 0.01 .. 1.0
  always_comb begin
    if (alpha_r < ALPHA_MIN) begin
      a_eff = ALPHA_MIN;
    end else if (alpha_r > ALPHA_ONE) begin
      a_eff = ALPHA_ONE;
    end else begin
      a_eff = alpha_r;
    end
  end

  // new sample in Q.14 and the magnitude of its distance to the average
  assign x_val   = {code_r, {FRAC_BITS{1'b0}}};
  assign neg_nxt = (x_val < s_r);
  assign mag     = neg_nxt ? (s_r - x_val) : (x_val - s_r);

  // filter pass: alpha * |x - s|, gain pass: s * gain
  always_comb begin
    if (state_r == ST_FILT) begin
      mreq.op_a = MUL_W'(a_eff);
      mreq.op_b = MUL_W'(mag);
    end else begin
      mreq.op_a = gain_r[range_r];
      mreq.op_b = MUL_W'(s_r);
    end
  end

  avf_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  // ewma: s*65536 + a*(x - s) + half, then drop 16 bits
  assign acc_base = AW'({s_r, 16'h0000}) + AW'(32'h0000_8000);
  assign acc_prod = AW'(prod_r[SW+16:0]);
  assign acc      = neg_r ? (acc_base - acc_prod) : (acc_base + acc_prod);

  // reading in microvolts, rounded half up, kept unsaturated
  assign prod_rnd = prod_r[SW+31:0] + (SW+32)'(32'h0020_0000);
  assign uv       = prod_rnd[SW+31:22];

  // ---------------------------------------------------------- range decision
  assign auto_mode = (mode_r >= MODE_AUTO);
  assign cool_ok   = ((now_r - last_r) >= 32'(cool_r));
  assign go_up     = (uv > UW'(UP_UV[range_r]));
  assign go_dn     = !go_up && (uv < UW'(DN_UV[range_r]));
  assign step      = !chg_r && auto_mode && cool_ok &&
                     ((go_up && (range_r < TOP)) || (go_dn && (range_r != '0)));
  assign over      = (uv > UW'(LIMIT_UV[range_r]));
  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r == ST_EVAL) && !step && slot_free;

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FILT;
      end
      ST_FILT:   state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (step) begin
          state_nxt = ST_MUL;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // item state updates
  always_comb begin
    s_nxt         = s_r;
    range_nxt     = range_r;
    last_nxt      = last_r;
    chg_nxt       = chg_r;
    prior_ovl_nxt = prior_ovl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        chg_nxt = 1'b0;
      end
      ST_SMOOTH: begin
        // zero average takes the sample as seed
        s_nxt = (s_r == '0) ? x_val : acc[SW+15:16];
        if (!auto_mode) begin
          range_nxt = (mode_r > TOP) ? TOP : mode_r;
        end
      end
      ST_EVAL: begin
        if (step) begin
          range_nxt = go_up ? (range_r + RANGE_W'(1)) : (range_r - RANGE_W'(1));
          last_nxt  = now_r;
          chg_nxt   = 1'b1;
        end else if (slot_free) begin
          prior_ovl_nxt = over;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_r         <= '0;
      range_r     <= RANGE_RST;
      last_r      <= '0;
      chg_r       <= 1'b0;
      prior_ovl_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_r         <= s_nxt;
      range_r     <= range_nxt;
      last_r      <= last_nxt;
      chg_r       <= chg_nxt;
      prior_ovl_r <= prior_ovl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and the sign of the filter step
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_adc_code;
      now_r  <= in_now_ms;
    end
    if (state_r == ST_FILT) begin
      neg_r <= neg_nxt;
    end
  end

  // result register, saturated to 32 bits
  always_ff @(posedge clk) begin
    if (load) begin
      uv_out_r      <= (uv > UW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : uv[31:0];
      range_out_r   <= range_r;
      chg_out_r     <= chg_r;
      ovl_out_r     <= over;
      ovl_chg_out_r <= (over != prior_ovl_r);
      filt_out_r    <= 24'(s_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_voltage_uv       = uv_out_r;
  assign out_range_index      = range_out_r;
  assign out_range_changed    = chg_out_r;
  assign out_overloaded       = ovl_out_r;
  assign out_overload_changed = ovl_chg_out_r;
  assign out_filtered_code    = filt_out_r;

  // ------------------------------------------------------------ assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  a_range_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    range_r <= TOP)
    else $error("active range above top range");

  a_prior_ovl_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (prior_ovl_r == out_overloaded))
    else $error("overload history not updated with result");

  a_step_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (!out_range_changed || (last_r == $past(now_r))))
    else $error("range step without cooldown timestamp");

endmodule
